// File: rtl/ffc_pkg.sv
`default_nettype none
package ffc_pkg;
    localparam int FracBits = 8;
    localparam int WordW    = 32;

    typedef enum logic [1:0] {
        OP_INT2FIX   = 2'd0,
        OP_FLT2FIX   = 2'd1,
        OP_FIX2INT   = 2'd2,
        OP_FIX2FLT   = 2'd3
    } t_opcode;
endpackage
`default_nettype wire

// File: rtl/fixed_float_converter_unit.sv
`default_nettype none
// Converts one 32-bit word per cycle between Q24.8 fixed point, int32 and IEEE
// single, as chosen by i_opcode, while o_stall is low. Each transfer passes a
// three-stage pipeline (decode and shift, round, saturate/negate and pack); an item
// may enter every cycle, and o_stall holds the whole pipeline in place. o_saturated
// is raised only by float to fixed, on clipping, infinity or NaN.
module fixed_float_converter_unit (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [1:0]              i_opcode,
    input  wire logic [ffc_pkg::WordW-1:0] i_operand_bits,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [ffc_pkg::WordW-1:0]    o_result_bits,
    output logic                         o_saturated
);
    import ffc_pkg::*;

    logic adv;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // Stage 1: decode and the main shift.
    logic [1:0]  r_op1, n_op1;
    logic        r_v1, r_v2, r_v3;
    logic        r_sign1, n_sign1;
    logic        r_spec1, n_spec1;     // infinity or NaN (float to fixed), or zero input (fixed to float)
    logic [31:0] r_direct1, n_direct1;
    logic [40:0] r_shv1, n_shv1;       // value; for float to fixed, with one guard bit at bit 0
    logic        r_big1, n_big1;
    logic [4:0]  r_p1, n_p1;           // leading one position (fixed to float)

    always_comb begin
        logic [7:0]  ex;
        logic [23:0] m;
        logic signed [10:0] e;
        logic [31:0] mag;
        logic [63:0] wide;
        n_op1 = i_opcode; n_sign1 = i_operand_bits[31]; n_spec1 = 1'b0;
        n_direct1 = '0; n_shv1 = '0; n_big1 = 1'b0; n_p1 = '0;
        ex = i_operand_bits[30:23];
        m = (ex == 8'd0) ? {1'b0, i_operand_bits[22:0]} : {1'b1, i_operand_bits[22:0]};
        e = (ex == 8'd0) ? 11'(-149 + FracBits) : 11'($signed({3'b0, ex}) - 150 + FracBits);
        mag = i_operand_bits[31] ? (32'd0 - i_operand_bits) : i_operand_bits;
        wide = '0;
        case (t_opcode'(i_opcode))
            OP_INT2FIX: n_direct1 = i_operand_bits << FracBits;
            OP_FIX2INT: n_direct1 = 32'($signed(i_operand_bits) >>> FracBits);
            OP_FLT2FIX: begin
                if (ex == 8'hFF) begin
                    n_spec1 = 1'b1;
                    n_direct1 = (i_operand_bits[22:0] != '0) ? 32'd0 :
                        (i_operand_bits[31] ? 32'h8000_0000 : 32'h7FFF_FFFF);
                end else if (m == '0) begin
                    n_shv1 = '0;
                end else if (e >= 0) begin
                    if (e > 11'sd39) n_big1 = 1'b1;
                    else begin
                        wide = {40'd0, m} << e[5:0];
                        n_big1 = wide[63:33] != '0;
                        n_shv1 = {wide[39:0], 1'b0};
                    end
                end else if (e >= -11'sd25) begin
                    wide = {m, 1'b0, 39'd0} >> (-e);
                    n_shv1 = {16'd0, wide[63:39]};
                end
            end
            default: begin
                for (int k = 0; k < 32; k++) if (mag[k]) n_p1 = 5'(k);
                n_shv1 = {9'd0, mag};
                n_spec1 = mag == '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (adv) r_v1 <= i_valid;
        if (adv) begin
            r_op1 <= n_op1; r_sign1 <= n_sign1; r_spec1 <= n_spec1;
            r_direct1 <= n_direct1; r_shv1 <= n_shv1; r_big1 <= n_big1; r_p1 <= n_p1;
        end
    end

    // Stage 2: rounding.
    logic [1:0]  r_op2;
    logic        r_sign2, r_spec2;
    logic [31:0] r_direct2, n_direct2;
    logic [32:0] r_mag2, n_mag2;
    logic [24:0] r_keep2, n_keep2;
    logic [4:0]  r_p2;

    always_comb begin
        logic [40:0] rnd;
        logic [31:0] mg, rem, half;
        logic [4:0]  s;
        n_direct2 = r_direct1; n_mag2 = '0; n_keep2 = '0;
        rnd = r_shv1 + 41'd1;
        mg = r_shv1[31:0];
        s = (r_p1 > 5'd23) ? r_p1 - 5'd23 : 5'd0;
        rem = mg & ((32'd1 << s) - 32'd1);
        half = (s == 5'd0) ? 32'd0 : (32'd1 << (s - 5'd1));
        if (r_op1 == OP_FLT2FIX) begin
            n_mag2 = (r_big1 || rnd[40:34] != '0) ? 33'h1_0000_0000 : rnd[33:1];
        end else if (r_op1 == OP_FIX2FLT) begin
            if (r_p1 <= 5'd23) n_keep2 = 25'(mg << (5'd23 - r_p1));
            else begin
                n_keep2 = 25'(mg >> s);
                if (rem > half || (rem == half && n_keep2[0])) n_keep2 = n_keep2 + 25'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (adv) r_v2 <= r_v1;
        if (adv) begin
            r_op2 <= r_op1; r_sign2 <= r_sign1; r_spec2 <= r_spec1;
            r_direct2 <= n_direct2; r_mag2 <= n_mag2; r_keep2 <= n_keep2; r_p2 <= r_p1;
        end
    end

    // Stage 3: saturation, negation and packing.
    logic [31:0] n_res3;
    logic        n_sat3;
    always_comb begin
        logic [24:0] k;
        logic [7:0]  pe;
        n_res3 = r_direct2; n_sat3 = 1'b0;
        k = r_keep2; pe = 8'(r_p2) + 8'(127 - FracBits);
        case (t_opcode'(r_op2))
            OP_FLT2FIX: begin
                if (r_spec2) n_sat3 = 1'b1;
                else if (r_sign2) begin
                    if (r_mag2 > 33'h0_8000_0000) begin
                        n_sat3 = 1'b1; n_res3 = 32'h8000_0000;
                    end else n_res3 = 32'd0 - r_mag2[31:0];
                end else if (r_mag2 > 33'h0_7FFF_FFFF) begin
                    n_sat3 = 1'b1; n_res3 = 32'h7FFF_FFFF;
                end else n_res3 = r_mag2[31:0];
            end
            OP_FIX2FLT: begin
                if (k[24]) begin k = k >> 1; pe = pe + 8'd1; end
                n_res3 = r_spec2 ? 32'd0 : {r_sign2, pe, k[22:0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (adv) r_v3 <= r_v2;
        if (adv) begin
            o_result_bits <= n_res3; o_saturated <= n_sat3;
        end
    end
    assign o_valid = r_v3;
endmodule
`default_nettype wire
